### hw/rtl/sle_pkg.sv
// Sorted list engine package: request and status codes, controller states and
// the per-cell control bundle. Used by the interfaces, sle_cell and the top level.
// No dependencies.
package sle_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_UPDATE = 1'b1
    } state_t;

    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 4;
    localparam int COUNT_W    = 5;

    // Control broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic flag_en;    // capture compare flags against the incoming value
        logic do_insert;  // open a slot at the insertion point and fill it
        logic do_remove;  // close the gap at the first match
    } cell_ctrl_t;

endpackage

### hw/rtl/sle_if.sv
// Handshake channels of the sorted list engine: request and response.
// Depends on sle_pkg.
interface sle_req_if;
    import sle_pkg::*;

    logic                       valid;
    logic                       ready;
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface sle_rsp_if;
    import sle_pkg::*;

    logic                   valid;
    logic                   ready;
    status_t                status;
    logic [POSITION_W-1:0]  position;
    logic [COUNT_W-1:0]     entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

### hw/rtl/sle_cell.sv
// One cell of the sorted chain: holds a single entry and its compare flags,
// and trades entries with its neighbors on insert and remove.
// Depends on sle_pkg.
module sle_cell (
    input  logic                                clk,
    input  sle_pkg::cell_ctrl_t                 ctrl,
    input  logic                                valid_in,
    input  logic signed [sle_pkg::VALUE_W-1:0]  cmp_value,
    input  logic signed [sle_pkg::VALUE_W-1:0]  req_value,
    input  logic signed [sle_pkg::VALUE_W-1:0]  left_entry,
    input  logic signed [sle_pkg::VALUE_W-1:0]  right_entry,
    input  logic                                left_lt,
    output logic signed [sle_pkg::VALUE_W-1:0]  entry,
    output logic                                lt,
    output logic                                boundary,
    output logic                                match
);
    import sle_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      lt_reg;
    logic                      eq_reg;

    // The flags form a thermometer along the sorted chain; the insertion point
    // is where it turns from smaller to not smaller.
    assign boundary = left_lt && !lt_reg;
    assign match    = boundary && eq_reg;
    assign entry    = entry_reg;
    assign lt       = lt_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.do_insert)
        begin
            if (boundary)
            begin
                entry_next = req_value;
            end
            else if (!left_lt)
            begin
                entry_next = left_entry;
            end
        end
        else if (ctrl.do_remove)
        begin
            if (!lt_reg)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.flag_en)
        begin
            lt_reg <= valid_in && (entry_reg < cmp_value);
            eq_reg <= valid_in && (entry_reg == cmp_value);
        end
    end

endmodule

### hw/rtl/sorted_list_engine_unit.sv
// Top level of the sorted list engine: controller, result register and the
// chain of sle_cell instances. Depends on sle_pkg, sle_if and sle_cell.
//
//   Channel  Direction  Handshake     Payload
//   req      in         valid/ready   op, value
//   rsp      out        valid/ready   status, position, entry_count
//
// At the accepting edge every cell compares its entry with the request value in
// parallel and registers the result. In the update state, once the response
// slot is free, the flags give the position, an insert or remove shifts the
// cells by one place and the response register is written. A response that is
// not taken lets one more request in but holds that request in the update
// state, so the request after it waits at the input. Reset empties the list by
// clearing the entry count; the stored entries are not cleared.
module sorted_list_engine_unit #(
    parameter int CAPACITY = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sle_req_if.sink    req,
    sle_rsp_if.source  rsp
);
    import sle_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IDXW = $clog2(CAPACITY);

    state_t                    state_reg;
    state_t                    state_next;
    op_t                       op_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;

    logic                      rsp_valid_reg;
    status_t                   status_reg;
    logic [POSITION_W-1:0]     position_reg;
    logic [COUNT_W-1:0]        entry_count_reg;

    logic                      accept;
    logic                      commit;
    logic                      slot_free;
    logic                      full;
    logic                      hit;
    logic [IDXW-1:0]           pos;
    status_t                   status_next;
    logic [IDXW-1:0]           pos_next;
    cell_ctrl_t                ctrl;

    logic signed [VALUE_W-1:0] cell_entry [CAPACITY];
    logic [CAPACITY-1:0]       cell_lt;
    logic [CAPACITY-1:0]       cell_boundary;
    logic [CAPACITY-1:0]       cell_match;
    logic [CAPACITY-1:0]       cell_valid;

    // The chain of cells. Cell 0 sees an imaginary smaller neighbor on its
    // left, so an empty list or a value below every entry inserts at the head.
    // The last cell takes its own entry when the gap closes past the end.
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                      left_lt;
            logic signed [VALUE_W-1:0] left_entry;
            logic signed [VALUE_W-1:0] right_entry;

            assign cell_valid[i] = (count_reg > CW'(i));

            if (i == 0)
            begin : g_head
                assign left_lt    = 1'b1;
                assign left_entry = value_reg;
            end
            else
            begin : g_body
                assign left_lt    = cell_lt[i-1];
                assign left_entry = cell_entry[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_entry = cell_entry[i];
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[i+1];
            end

            sle_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .valid_in    (cell_valid[i]),
                .cmp_value   (req.value),
                .req_value   (value_reg),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .left_lt     (left_lt),
                .entry       (cell_entry[i]),
                .lt          (cell_lt[i]),
                .boundary    (cell_boundary[i]),
                .match       (cell_match[i])
            );
        end
    endgenerate

    // At most one cell sees the boundary, so the position is a plain OR of
    // the indexes. No boundary means every held entry is smaller and the list
    // is full; neither a hit nor an insert can follow then.
    always_comb
    begin
        pos = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (cell_boundary[k])
            begin
                pos = pos | IDXW'(k);
            end
        end
    end

    assign hit       = |cell_match;
    assign full      = (count_reg == CW'(CAPACITY));
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        req.ready      = (state_reg == S_IDLE);
        commit         = (state_reg == S_UPDATE) && slot_free;
        ctrl.flag_en   = (state_reg == S_IDLE) && req.valid;
        ctrl.do_insert = commit && (op_reg == OP_INSERT) && !full;
        ctrl.do_remove = commit && (op_reg == OP_REMOVE) && hit;
    end

    // Response and new entry count for the request in the update cycle.
    always_comb
    begin
        status_next = ST_DONE;
        pos_next    = '0;
        count_next  = count_reg;
        case (op_reg)
            OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    pos_next   = pos;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_SEARCH, OP_REMOVE:
            begin
                if (hit)
                begin
                    pos_next = pos;
                    if (op_reg == OP_REMOVE)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.op;
            value_reg <= req.value;
        end
        if (commit)
        begin
            status_reg      <= status_next;
            position_reg    <= POSITION_W'(pos_next);
            entry_count_reg <= COUNT_W'(count_next);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.position    = position_reg;
    assign rsp.entry_count = entry_count_reg;

endmodule
